// ===== rtl/vc_pkg.sv =====
package vc_pkg;

   localparam int SLOT_COUNT = 16;
   localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   localparam int OP_W     = 3;
   localparam int MONEY_W  = 16;
   localparam int SLOT_W   = 4;
   localparam int QTY_W    = 8;
   localparam int STATUS_W = 4;
   localparam int MODE_W   = 2;

   localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
   localparam logic [OP_W-1:0] OP_SELECT   = 3'd1;
   localparam logic [OP_W-1:0] OP_DISPENSE = 3'd2;
   localparam logic [OP_W-1:0] OP_REFUND   = 3'd3;
   localparam logic [OP_W-1:0] OP_LOAD     = 3'd4;

   localparam logic [STATUS_W-1:0] ST_ACCEPTED     = 4'd0;
   localparam logic [STATUS_W-1:0] ST_INSERT_FIRST = 4'd1;
   localparam logic [STATUS_W-1:0] ST_NOTHING      = 4'd2;
   localparam logic [STATUS_W-1:0] ST_OUT_OF_STOCK = 4'd3;
   localparam logic [STATUS_W-1:0] ST_INSUFFICIENT = 4'd4;
   localparam logic [STATUS_W-1:0] ST_SELECTED     = 4'd5;
   localparam logic [STATUS_W-1:0] ST_SELECT_FIRST = 4'd6;
   localparam logic [STATUS_W-1:0] ST_REFUNDED     = 4'd7;
   localparam logic [STATUS_W-1:0] ST_BUSY         = 4'd8;
   localparam logic [STATUS_W-1:0] ST_ALREADY      = 4'd9;
   localparam logic [STATUS_W-1:0] ST_DISPENSED    = 4'd10;
   localparam logic [STATUS_W-1:0] ST_LOADED       = 4'd11;

   localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MONEY = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DISP  = 2'd2;

   typedef struct packed {
      logic [MONEY_W-1:0] price;
      logic [QTY_W-1:0]   stock;
   } slot_entry_type;

endpackage

// ===== rtl/vending_controller.sv =====
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/ready    operation, amount, slot, price, quantity
// rsp_      out        rsp_valid/ready    status, returned_money, needed_price,
//                                         credit, mode, dispensed_slot
//
// From acceptance to result an item passes the slot table read, then the evaluate and
// write-back step. One item per cycle is sustained while the result side does not stall;
// the slot table has one read and one write port, and a bypass register covers a read
// of the entry being written in the same cycle. Reset is synchronous and clears mode,
// credit, chosen slot and the stock valid bits. A stalled result holds the evaluate
// stage, and the request side then stalls. Operation codes 5 to 7 are taken and dropped.
module vending_controller (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [vc_pkg::OP_W-1:0]         req_operation,
   input  logic [vc_pkg::MONEY_W-1:0]      req_amount,
   input  logic [vc_pkg::SLOT_W-1:0]       req_slot,
   input  logic [vc_pkg::MONEY_W-1:0]      req_price,
   input  logic [vc_pkg::QTY_W-1:0]        req_quantity,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [vc_pkg::STATUS_W-1:0]     rsp_status,
   output logic [vc_pkg::MONEY_W-1:0]      rsp_returned_money,
   output logic [vc_pkg::MONEY_W-1:0]      rsp_needed_price,
   output logic [vc_pkg::MONEY_W-1:0]      rsp_credit,
   output logic [vc_pkg::MODE_W-1:0]       rsp_mode,
   output logic [vc_pkg::SLOT_W-1:0]       rsp_dispensed_slot
);
   import vc_pkg::*;

   // Architectural state.
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [MONEY_W-1:0] credit_ff, credit_in;
   logic [SLOT_W-1:0]  chosen_ff, chosen_in;

   // Slot table and its valid bits.
   slot_entry_type         slot_mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0]  slot_vld_ff;
   slot_entry_type         rd_entry_ff;
   logic                   rd_vld_ff;
   logic                   byp_hit_ff;
   slot_entry_type         byp_entry_ff;

   // Evaluate stage.
   logic                s1_valid_ff;
   logic [OP_W-1:0]     s1_op_ff;
   logic [MONEY_W-1:0]  s1_amount_ff;
   logic [SLOT_W-1:0]   s1_slot_ff;
   logic [MONEY_W-1:0]  s1_price_ff;
   logic [QTY_W-1:0]    s1_qty_ff;

   // Result register.
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [MONEY_W-1:0]  rsp_returned_ff;
   logic [MONEY_W-1:0]  rsp_needed_ff;
   logic [MONEY_W-1:0]  rsp_credit_ff;
   logic [MODE_W-1:0]   rsp_mode_ff;
   logic [SLOT_W-1:0]   rsp_dslot_ff;

   logic                accept;
   logic                s1_adv;
   logic [SLOT_W-1:0]   rd_slot;
   logic [SLOT_IDX_W-1:0] rd_addr;

   slot_entry_type      entry;
   logic [QTY_W-1:0]    stock_cur;
   logic                s1_slot_ok;
   logic                chosen_ok;
   logic [MONEY_W:0]    credit_sum;
   logic [MONEY_W-1:0]  credit_add;
   logic [MONEY_W-1:0]  disp_price;

   logic [STATUS_W-1:0] res_status;
   logic [MONEY_W-1:0]  res_returned;
   logic [MONEY_W-1:0]  res_needed;
   logic [MONEY_W-1:0]  res_credit;
   logic [MODE_W-1:0]   res_mode;
   logic [SLOT_W-1:0]   res_chosen;
   logic [SLOT_W-1:0]   res_dslot;
   logic                wr_en;
   logic [SLOT_IDX_W-1:0] wr_addr;
   slot_entry_type      wr_data;
   logic                mem_we;

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept    = req_valid && req_ready;

   // A dispense reads the chosen slot as it stands after the item now being evaluated.
   assign rd_slot = (req_operation == OP_DISPENSE) ? chosen_in : req_slot;
   assign rd_addr = SLOT_IDX_W'(rd_slot);

   assign entry      = byp_hit_ff ? byp_entry_ff : rd_entry_ff;
   assign stock_cur  = (byp_hit_ff || rd_vld_ff) ? entry.stock : '0;
   assign s1_slot_ok = int'(s1_slot_ff) < SLOT_COUNT;
   assign chosen_ok  = int'(chosen_ff) < SLOT_COUNT;
   assign credit_sum = {1'b0, credit_ff} + {1'b0, s1_amount_ff};
   assign credit_add = credit_sum[MONEY_W] ? '1 : credit_sum[MONEY_W-1:0];
   assign disp_price = chosen_ok ? entry.price : '0;

   always_comb begin
      res_status   = ST_LOADED;
      res_returned = '0;
      res_needed   = '0;
      res_credit   = credit_ff;
      res_mode     = mode_ff;
      res_chosen   = chosen_ff;
      res_dslot    = '0;
      wr_en        = 1'b0;
      wr_addr      = SLOT_IDX_W'(s1_slot_ff);
      wr_data      = '{price: s1_price_ff, stock: s1_qty_ff};
      if (s1_op_ff == OP_LOAD) begin
         wr_en = s1_slot_ok;
      end else begin
         unique case (mode_ff)
            MODE_IDLE: begin
               case (s1_op_ff)
                  OP_INSERT: begin
                     res_credit = credit_add;
                     res_mode   = MODE_MONEY;
                     res_status = ST_ACCEPTED;
                  end
                  OP_REFUND: res_status = ST_NOTHING;
                  default:   res_status = ST_INSERT_FIRST;
               endcase
            end
            MODE_MONEY: begin
               case (s1_op_ff)
                  OP_INSERT: begin
                     res_credit = credit_add;
                     res_status = ST_ACCEPTED;
                  end
                  OP_SELECT: begin
                     if (!s1_slot_ok || stock_cur == '0) begin
                        res_status = ST_OUT_OF_STOCK;
                     end else if (credit_ff < entry.price) begin
                        res_status = ST_INSUFFICIENT;
                        res_needed = entry.price;
                     end else begin
                        res_chosen = s1_slot_ff;
                        res_mode   = MODE_DISP;
                        res_status = ST_SELECTED;
                     end
                  end
                  OP_DISPENSE: res_status = ST_SELECT_FIRST;
                  default: begin
                     res_returned = credit_ff;
                     res_credit   = '0;
                     res_mode     = MODE_IDLE;
                     res_status   = ST_REFUNDED;
                  end
               endcase
            end
            default: begin
               case (s1_op_ff)
                  OP_INSERT: res_status = ST_BUSY;
                  OP_SELECT: res_status = ST_ALREADY;
                  OP_DISPENSE: begin
                     // Stock already at zero stays at zero; the dispense still completes.
                     wr_en        = chosen_ok && (stock_cur != '0);
                     wr_addr      = SLOT_IDX_W'(chosen_ff);
                     wr_data      = '{price: entry.price, stock: stock_cur - 1'b1};
                     res_returned = (credit_ff > disp_price) ? credit_ff - disp_price : '0;
                     res_dslot    = chosen_ff;
                     res_credit   = '0;
                     res_chosen   = '0;
                     res_mode     = MODE_IDLE;
                     res_status   = ST_DISPENSED;
                  end
                  default: begin
                     res_returned = credit_ff;
                     res_credit   = '0;
                     res_chosen   = '0;
                     res_mode     = MODE_IDLE;
                     res_status   = ST_REFUNDED;
                  end
               endcase
            end
         endcase
      end
   end

   assign mem_we    = s1_adv && wr_en;
   assign mode_in   = s1_adv ? res_mode : mode_ff;
   assign credit_in = s1_adv ? res_credit : credit_ff;
   assign chosen_in = s1_adv ? res_chosen : chosen_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (accept) begin
         rd_entry_ff  <= slot_mem[rd_addr];
         byp_entry_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_vld_ff <= '0;
         rd_vld_ff   <= 1'b0;
         byp_hit_ff  <= 1'b0;
         mode_ff     <= MODE_IDLE;
         credit_ff   <= '0;
         chosen_ff   <= '0;
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (mem_we) begin
            slot_vld_ff[wr_addr] <= 1'b1;
         end
         if (accept) begin
            rd_vld_ff  <= slot_vld_ff[rd_addr];
            byp_hit_ff <= mem_we && (wr_addr == rd_addr);
         end
         mode_ff   <= mode_in;
         credit_ff <= credit_in;
         chosen_ff <= chosen_in;
         if (accept) begin
            s1_valid_ff <= (req_operation <= OP_LOAD);
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff     <= req_operation;
         s1_amount_ff <= req_amount;
         s1_slot_ff   <= req_slot;
         s1_price_ff  <= req_price;
         s1_qty_ff    <= req_quantity;
      end
      if (s1_adv) begin
         rsp_status_ff   <= res_status;
         rsp_returned_ff <= res_returned;
         rsp_needed_ff   <= res_needed;
         rsp_credit_ff   <= res_credit;
         rsp_mode_ff     <= res_mode;
         rsp_dslot_ff    <= res_dslot;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_returned_money = rsp_returned_ff;
   assign rsp_needed_price   = rsp_needed_ff;
   assign rsp_credit         = rsp_credit_ff;
   assign rsp_mode           = rsp_mode_ff;
   assign rsp_dispensed_slot = rsp_dslot_ff;

   a_idle_no_credit: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_IDLE |-> credit_ff == '0)
      else $error("credit held while idle");

   a_chosen_only_disp: assert property (@(posedge clock) disable iff (reset)
      chosen_ff != '0 |-> mode_ff == MODE_DISP)
      else $error("chosen slot set outside dispensing");

   a_dispensed_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_DISPENSED
         |-> rsp_mode_ff == MODE_IDLE && rsp_credit_ff == '0)
      else $error("dispense left credit or mode");

   a_insufficient: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_INSUFFICIENT |-> rsp_needed_ff > rsp_credit_ff)
      else $error("insufficient reported with enough credit");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_op_ff) && $stable(s1_slot_ff))
      else $error("evaluate stage lost a stalled item");

endmodule
